// File: rtl/sita_pkg.sv
// ----------------------------------------------------------------------------
// sita_pkg: shared definitions for the signed integer to ASCII converter
// Widths, character codes, controller states and the converter status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package sita_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int BCD_W       = NUM_DIGITS * 4;
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
	localparam int NLEFT_W     = $clog2(NUM_DIGITS + 1);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_DIGIT
	} state_t;

	typedef struct packed {
		logic             done;
		logic [BCD_W-1:0] bcd;
	} conv_t;

endpackage

`default_nettype wire

// File: rtl/sita_dabble.sv
// ----------------------------------------------------------------------------
// sita_dabble: bit-serial binary to BCD converter
// Shifts the magnitude in one bit per cycle, adjusting each BCD digit first.
// ----------------------------------------------------------------------------
`default_nettype none

module sita_dabble (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           load,
	input  wire logic [sita_pkg::VALUE_WIDTH-1:0] mag,
	output sita_pkg::conv_t                     conv
);

	logic [sita_pkg::VALUE_WIDTH-1:0] bin_q;
	logic [sita_pkg::BCD_W-1:0]       bcd_q;
	logic [sita_pkg::CNT_W-1:0]       cnt_q;
	logic [sita_pkg::BCD_W-1:0]       bcd_adj;

	always_comb begin
		for (int i = 0; i < sita_pkg::NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= sita_pkg::CNT_W'(sita_pkg::VALUE_WIDTH);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - sita_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bin_q <= {bin_q[sita_pkg::VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {bcd_adj[sita_pkg::BCD_W-2:0], bin_q[sita_pkg::VALUE_WIDTH-1]};
		end
	end

	assign conv.done = (cnt_q == '0);
	assign conv.bcd  = bcd_q;

endmodule

`default_nettype wire

// File: rtl/sita_emit.sv
// ----------------------------------------------------------------------------
// sita_emit: character sequencer
// Emits a minus sign for negative values, drops leading zeros and sends digits most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module sita_emit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire logic            neg,
	input  wire sita_pkg::conv_t conv,
	output logic                 busy,
	output logic [7:0]           char_code,
	output logic                 last,
	output logic                 strobe
);

	sita_pkg::state_t state_q, state_d;

	logic [sita_pkg::BCD_W-1:0]   dig_q;
	logic [sita_pkg::NLEFT_W-1:0] nleft_q;
	logic                         neg_q;
	logic                         strobe_q;
	logic [7:0]                   char_q;
	logic                         last_q;

	logic       cap;
	logic       shift;
	logic       emit;
	logic [7:0] ch;
	logic       lst;
	logic [3:0] top;
	logic       one_left;
	logic       lead_zero;

	assign top       = dig_q[sita_pkg::BCD_W-1 -: 4];
	assign one_left  = (nleft_q == sita_pkg::NLEFT_W'(1));
	assign lead_zero = (top == 4'd0) && !one_left;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sita_pkg::ST_IDLE: begin
				if (load) state_d = sita_pkg::ST_CONV;
			end
			sita_pkg::ST_CONV: begin
				if (conv.done) state_d = neg_q ? sita_pkg::ST_SIGN : sita_pkg::ST_SKIP;
			end
			sita_pkg::ST_SIGN: begin
				state_d = sita_pkg::ST_SKIP;
			end
			sita_pkg::ST_SKIP: begin
				if (!lead_zero) state_d = one_left ? sita_pkg::ST_IDLE : sita_pkg::ST_DIGIT;
			end
			sita_pkg::ST_DIGIT: begin
				if (one_left) state_d = sita_pkg::ST_IDLE;
			end
			default: state_d = sita_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cap   = 1'b0;
		shift = 1'b0;
		emit  = 1'b0;
		ch    = sita_pkg::CHAR_ZERO + {4'd0, top};
		lst   = 1'b0;
		unique case (state_q)
			sita_pkg::ST_IDLE: begin
			end
			sita_pkg::ST_CONV: begin
				cap = conv.done;
			end
			sita_pkg::ST_SIGN: begin
				emit = 1'b1;
				ch   = sita_pkg::CHAR_MINUS;
			end
			sita_pkg::ST_SKIP: begin
				shift = 1'b1;
				emit  = !lead_zero;
				lst   = one_left;
			end
			sita_pkg::ST_DIGIT: begin
				shift = 1'b1;
				emit  = 1'b1;
				lst   = one_left;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sita_pkg::ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		char_q <= ch;
		last_q <= lst;
		if (load) begin
			neg_q <= neg;
		end
		if (cap) begin
			dig_q   <= conv.bcd;
			nleft_q <= sita_pkg::NLEFT_W'(sita_pkg::NUM_DIGITS);
		end else if (shift) begin
			dig_q   <= {dig_q[sita_pkg::BCD_W-5:0], 4'd0};
			nleft_q <= nleft_q - sita_pkg::NLEFT_W'(1);
		end
	end

	assign busy      = (state_q != sita_pkg::ST_IDLE);
	assign char_code = char_q;
	assign last      = last_q;
	assign strobe    = strobe_q;

endmodule

`default_nettype wire

// File: rtl/signed_int_to_ascii_decimal.sv
// ----------------------------------------------------------------------------
// signed_int_to_ascii_decimal: signed integer to ASCII decimal text
// Converts one two's-complement integer into its decimal characters.
// ----------------------------------------------------------------------------
// Channel   Handshake         Payload
// input     start / busy      value
// output    strobe            char_code, last
//
// An item is taken when start is high and busy is low.
// Busy covers the bit-serial BCD conversion, a minus sign for negative values,
// then a pass over all NUM_DIGITS digit positions that drops leading zeros and
// sends the digits.
// The next item is taken in the cycle that shows the last character.
// Reset clears the sequencer, the strobe and the converter's bit counter; results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_ascii_decimal (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [sita_pkg::VALUE_WIDTH-1:0] value,
	output logic [7:0]                                 char_code,
	output logic                                       last,
	output logic                                       strobe
);

	logic                             load;
	logic [sita_pkg::VALUE_WIDTH-1:0] raw;
	logic [sita_pkg::VALUE_WIDTH-1:0] mag;
	sita_pkg::conv_t                  conv;

	assign load = start && !busy;
	assign raw  = value;
	assign mag  = raw[sita_pkg::VALUE_WIDTH-1] ? (~raw + sita_pkg::VALUE_WIDTH'(1)) : raw;

	sita_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.mag    (mag),
		.conv   (conv)
	);

	sita_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.neg       (raw[sita_pkg::VALUE_WIDTH-1]),
		.conv      (conv),
		.busy      (busy),
		.char_code (char_code),
		.last      (last),
		.strobe    (strobe)
	);

endmodule

`default_nettype wire

// File: rtl/sita_checker.sv
// ----------------------------------------------------------------------------
// sita_checker: port-level checks for the converter
// Watches the command handshake and the character stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sita_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [7:0] char_code,
	input wire logic       last,
	input wire logic       strobe
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !strobe)
		else $error("accepted item did not raise busy");

	a_mid_char_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final character outside busy");

	a_end_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("character right after final character");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && char_code == sita_pkg::CHAR_MINUS |-> !last)
		else $error("minus sign marked final");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last)
		else $error("busy dropped without final character");

endmodule

bind signed_int_to_ascii_decimal sita_checker u_sita_checker (.*);

`default_nettype wire
